@@ sv/qvr_pkg.sv @@
// Package with the shared types and constants of the quaternion vector rotation block.
package qvr_pkg;

  localparam int MagW     = 32;
  localparam int SumW     = 64;
  localparam int LenW     = 32;
  localparam int QuoW     = 25;
  localparam int UnitW    = 26;
  localparam int QuatW    = 16;
  localparam int OutW     = 18;
  localparam int ResW     = 62;
  localparam int OutShift = 38;
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 25;
  localparam int PreTarget = 30;

  localparam logic [1:0] CfgQuatW = 2'd0;
  localparam logic [1:0] CfgQuatX = 2'd1;
  localparam logic [1:0] CfgQuatY = 2'd2;
  localparam logic [1:0] CfgQuatZ = 2'd3;

  localparam logic signed [QuatW-1:0] QuatWReset = 16'sd16384;

  localparam logic signed [OutW-1:0] OutMax = 18'sd131071;
  localparam logic signed [OutW-1:0] OutMin = -18'sd131072;

  typedef struct packed {
    logic signed [QuatW-1:0] w;
    logic signed [QuatW-1:0] x;
    logic signed [QuatW-1:0] y;
    logic signed [QuatW-1:0] z;
  } qvr_quat_t;

  // Magnitudes, effective signs and flags of one vector.
  typedef struct packed {
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic                 wnz;
    logic                 zero;
  } qvr_side_t;

  // Unit vector in Q.24 plus flags.
  typedef struct packed {
    logic signed [UnitW-1:0] ux;
    logic signed [UnitW-1:0] uy;
    logic signed [UnitW-1:0] uz;
    logic                    wnz;
    logic                    zero;
  } qvr_unit_t;

endpackage

@@ sv/qvr_in_if.sv @@
// Input channel interface carrying one homogeneous vector per transaction.
interface qvr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] vec_w;

  modport source (output valid, vec_x, vec_y, vec_z, vec_w, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

@@ sv/qvr_out_if.sv @@
// Result channel interface carrying one rotated vector per transaction.
interface qvr_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] out_x;
  logic signed [17:0] out_y;
  logic signed [17:0] out_z;
  logic               out_w;
  logic               zero_length;

  modport source (output valid, out_x, out_y, out_z, out_w, zero_length, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, zero_length, output ready);
endinterface

@@ sv/qvr_norm.sv @@
// Magnitude extraction, prescale and sum of squares, five pipeline stages.
module qvr_norm (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     valid_i,
  input  logic signed [31:0]       vec_x,
  input  logic signed [31:0]       vec_y,
  input  logic signed [31:0]       vec_z,
  input  logic signed [31:0]       vec_w,
  output logic                     valid_o,
  output qvr_pkg::qvr_side_t       side_o,
  output logic [qvr_pkg::SumW-1:0] sum_o
);
  import qvr_pkg::*;

  logic [4:0]      v_r;
  qvr_side_t       s1_r, s2_r, s3_r, s4_r, s5_r;
  qvr_side_t       s1_nxt, s3_nxt;
  logic [4:0]      sh_r, sh_nxt;
  logic [MagW-1:0] orv;
  logic [4:0]      msb;
  logic [SumW-1:0] sq_r [3];
  logic [SumW-1:0] sum_r;
  logic [2:0][31:0] vin;

  assign vin = {vec_z, vec_y, vec_x};

  always_comb begin
    s1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      s1_nxt.mag[i] = vin[i][31] ? (~vin[i] + 32'd1) : vin[i];
      s1_nxt.neg[i] = vin[i][31] ^ vec_w[31];
    end
    s1_nxt.wnz  = |vec_w;
    s1_nxt.zero = ~|{vec_x, vec_y, vec_z};
  end

  // The leading one of the OR of the magnitudes is that of the largest one.
  assign orv = s1_r.mag[0] | s1_r.mag[1] | s1_r.mag[2];

  always_comb begin
    msb = '0;
    for (int i = 0; i < MagW; i++) begin
      if (orv[i]) msb = 5'(i);
    end
    sh_nxt = (msb >= 5'(PreTarget)) ? 5'd0 : 5'(PreTarget) - msb;
  end

  always_comb begin
    s3_nxt = s2_r;
    for (int i = 0; i < 3; i++) s3_nxt.mag[i] = s2_r.mag[i] << sh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s1_r;
      sh_r  <= sh_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s3_r;
      s5_r  <= s4_r;
      for (int i = 0; i < 3; i++) sq_r[i] <= SumW'(s3_r.mag[i]) * SumW'(s3_r.mag[i]);
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  assign valid_o = v_r[4];
  assign side_o  = s5_r;
  assign sum_o   = sum_r;
endmodule

@@ sv/qvr_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module qvr_isqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     valid_i,
  input  qvr_pkg::qvr_side_t       side_i,
  input  logic [qvr_pkg::SumW-1:0] sum_i,
  output logic                     valid_o,
  output qvr_pkg::qvr_side_t       side_o,
  output logic [qvr_pkg::LenW-1:0] len_o
);
  import qvr_pkg::*;

  logic [33:0]     rem_a  [SqrtSteps+1];
  logic [LenW-1:0] root_a [SqrtSteps+1];
  logic [SumW-1:0] rad_a  [SqrtSteps+1];
  qvr_side_t       side_a [SqrtSteps+1];
  logic            v_a    [SqrtSteps+1];

  assign rem_a[0]  = '0;
  assign root_a[0] = '0;
  assign rad_a[0]  = sum_i;
  assign side_a[0] = side_i;
  assign v_a[0]    = valid_i;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
    logic [35:0] cur, trial;
    logic        ge;

    assign cur   = {rem_a[i], rad_a[i][SumW-1 -: 2]};
    assign trial = {2'b00, root_a[i], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_a[i+1] <= 1'b0;
      end else if (adv) begin
        v_a[i+1] <= v_a[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_a[i+1]  <= ge ? 34'(cur - trial) : 34'(cur);
        root_a[i+1] <= {root_a[i][LenW-2:0], ge};
        rad_a[i+1]  <= rad_a[i] << 2;
        side_a[i+1] <= side_a[i];
      end
    end
  end

  assign valid_o = v_a[SqrtSteps];
  assign side_o  = side_a[SqrtSteps];
  assign len_o   = root_a[SqrtSteps];
endmodule

@@ sv/qvr_div.sv @@
// Pipelined restoring division of the three magnitudes by the length, with rounding.
module qvr_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     valid_i,
  input  qvr_pkg::qvr_side_t       side_i,
  input  logic [qvr_pkg::LenW-1:0] len_i,
  output logic                     valid_o,
  output qvr_pkg::qvr_unit_t       unit_o
);
  import qvr_pkg::*;

  logic [32:0]     rem_a  [DivSteps+1][3];
  logic [QuoW-1:0] nb_a   [DivSteps+1][3];
  logic [QuoW-1:0] quo_a  [DivSteps+1][3];
  logic [LenW-1:0] len_a  [DivSteps+1];
  qvr_side_t       side_a [DivSteps+1];
  logic            v_a    [DivSteps+1];

  qvr_unit_t       unit_r;
  logic            v_r;
  logic signed [UnitW-1:0] u_nxt [3];

  // The quotient stays below 2^25, so the upper numerator bits start as the remainder.
  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rem_a[0][l] = {2'b00, side_i.mag[l][MagW-1:1]};
    assign nb_a[0][l]  = {side_i.mag[l][0], 24'd0};
    assign quo_a[0][l] = '0;
  end
  assign len_a[0]  = len_i;
  assign side_a[0] = side_i;
  assign v_a[0]    = valid_i;

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [32:0] cur [3];
    logic        ge  [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        cur[l] = {rem_a[i][l][31:0], nb_a[i][l][QuoW-1]};
        ge[l]  = cur[l] >= {1'b0, len_a[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_a[i+1] <= 1'b0;
      end else if (adv) begin
        v_a[i+1] <= v_a[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          rem_a[i+1][l] <= ge[l] ? cur[l] - {1'b0, len_a[i]} : cur[l];
          nb_a[i+1][l]  <= nb_a[i][l] << 1;
          quo_a[i+1][l] <= {quo_a[i][l][QuoW-2:0], ge[l]};
        end
        len_a[i+1]  <= len_a[i];
        side_a[i+1] <= side_a[i];
      end
    end
  end

  // Round half away from zero, then apply the sign.
  always_comb begin
    logic [UnitW-1:0] qr;
    for (int l = 0; l < 3; l++) begin
      qr = UnitW'(quo_a[DivSteps][l])
         + UnitW'({rem_a[DivSteps][l][31:0], 1'b0} >= {1'b0, len_a[DivSteps]});
      u_nxt[l] = side_a[DivSteps].neg[l] ? -$signed(qr) : $signed(qr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_a[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unit_r.ux   <= u_nxt[0];
      unit_r.uy   <= u_nxt[1];
      unit_r.uz   <= u_nxt[2];
      unit_r.wnz  <= side_a[DivSteps].wnz;
      unit_r.zero <= side_a[DivSteps].zero;
    end
  end

  assign valid_o = v_r;
  assign unit_o  = unit_r;
endmodule

@@ sv/qvr_rot.sv @@
// Rotation arithmetic q*p*conj(q), output rounding and the output register.
module qvr_rot (
  input  logic               clk,
  input  logic               rst_n,
  input  qvr_pkg::qvr_quat_t quat,
  input  logic               valid_i,
  input  qvr_pkg::qvr_unit_t unit_i,
  output logic               adv,
  qvr_out_if.source          out_ch
);
  import qvr_pkg::*;

  // Quaternion terms, refreshed every cycle from the registers.
  logic signed [31:0] qq_r [4];
  logic signed [33:0] s_r;

  logic [4:0] v_r;
  logic       wnz_r [5];
  logic       zero_r [5];

  logic signed [UnitW-1:0] u1_r [3];
  logic signed [UnitW-1:0] u2_r [3];
  logic signed [41:0] pd_r [3];
  logic signed [41:0] pc_r [6];
  logic signed [43:0] d_r;
  logic signed [42:0] c_r [3];
  logic signed [59:0] su_r [3];
  logic signed [59:0] dq_r [3];
  logic signed [58:0] wc_r [3];
  logic signed [ResW-1:0] r_r [3];
  logic signed [OutW-1:0] o_r [3];
  logic signed [OutW-1:0] o_nxt [3];
  logic signed [QuatW-1:0] qv [3];

  assign qv[0] = quat.x;
  assign qv[1] = quat.y;
  assign qv[2] = quat.z;

  assign adv = !v_r[4] || out_ch.ready;

  always_ff @(posedge clk) begin
    qq_r[0] <= quat.w * quat.w;
    qq_r[1] <= quat.x * quat.x;
    qq_r[2] <= quat.y * quat.y;
    qq_r[3] <= quat.z * quat.z;
    s_r     <= 34'(qq_r[0]) - 34'(qq_r[1]) - 34'(qq_r[2]) - 34'(qq_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], valid_i};
    end
  end

  // Round half away from zero at 2^38 and saturate to Q3.14.
  always_comb begin
    logic [ResW-1:0] mag;
    logic [ResW-1:0] rnd;
    logic [23:0]     q;
    for (int i = 0; i < 3; i++) begin
      mag = r_r[i][ResW-1] ? ResW'(-r_r[i]) : ResW'(r_r[i]);
      rnd = mag + (ResW'(1) << (OutShift - 1));
      q   = rnd[ResW-1-:24];
      if (zero_r[3]) begin
        o_nxt[i] = '0;
      end else if (r_r[i][ResW-1]) begin
        o_nxt[i] = (q > 24'd131072) ? OutMin : -$signed(OutW'(q));
      end else begin
        o_nxt[i] = (q > 24'd131071) ? OutMax : $signed(OutW'(q));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wnz_r[0]  <= unit_i.wnz;
      zero_r[0] <= unit_i.zero;
      for (int k = 1; k < 5; k++) begin
        wnz_r[k]  <= wnz_r[k-1];
        zero_r[k] <= zero_r[k-1];
      end
      u1_r[0] <= unit_i.ux;
      u1_r[1] <= unit_i.uy;
      u1_r[2] <= unit_i.uz;
      pd_r[0] <= quat.x * unit_i.ux;
      pd_r[1] <= quat.y * unit_i.uy;
      pd_r[2] <= quat.z * unit_i.uz;
      pc_r[0] <= quat.y * unit_i.uz;
      pc_r[1] <= quat.z * unit_i.uy;
      pc_r[2] <= quat.z * unit_i.ux;
      pc_r[3] <= quat.x * unit_i.uz;
      pc_r[4] <= quat.x * unit_i.uy;
      pc_r[5] <= quat.y * unit_i.ux;
      // Dot and cross products.
      u2_r    <= u1_r;
      d_r     <= 44'(pd_r[0]) + 44'(pd_r[1]) + 44'(pd_r[2]);
      c_r[0]  <= 43'(pc_r[0]) - 43'(pc_r[1]);
      c_r[1]  <= 43'(pc_r[2]) - 43'(pc_r[3]);
      c_r[2]  <= 43'(pc_r[4]) - 43'(pc_r[5]);
      for (int i = 0; i < 3; i++) begin
        su_r[i] <= s_r * u2_r[i];
        dq_r[i] <= d_r * qv[i];
        wc_r[i] <= c_r[i] * quat.w;
        r_r[i]  <= ResW'(su_r[i]) + (ResW'(dq_r[i]) <<< 1) + (ResW'(wc_r[i]) <<< 1);
        o_r[i]  <= o_nxt[i];
      end
    end
  end

  assign out_ch.valid       = v_r[4];
  assign out_ch.out_x       = o_r[0];
  assign out_ch.out_y       = o_r[1];
  assign out_ch.out_z       = o_r[2];
  assign out_ch.out_w       = wnz_r[4];
  assign out_ch.zero_length = zero_r[4];
endmodule

@@ sv/quaternion_vector_rotation_top.sv @@
// Top level of the quaternion vector rotation block: configuration registers and pipeline.
// The block rotates a stream of homogeneous vectors (vec_x, vec_y, vec_z, vec_w) by the
// quaternion held in four Q2.14 registers. The direction is sign(vec_w) times (x, y, z),
// normalized to unit length, and the result is the vector part of q*p*conj(q) in Q3.14,
// rounded to nearest and saturated; a quaternion of non-unit length scales the result by
// its squared length. out_w reports a nonzero weight, and zero_length flags an all-zero
// vector, whose outputs are then zero. The block takes one transaction in every cycle
// unless the result side stalls, and delivers one result per transaction, in order,
// through five stages of magnitude, prescale and sum of squares, 32 stages of square root
// (one root bit each), 26 stages of division and rounding (one quotient bit in each but
// the last), and five stages of rotation products, sums and output rounding, the last of
// which is the output register. When the result side stalls, the whole pipeline holds, so
// input ready follows output ready whenever a result is waiting. The quaternion registers
// are written through the cfg_ port (index 0 to 3 for w, x, y, z; reset is the identity
// rotation); the user must do so only while the block is idle, which it does not enforce.
module quaternion_vector_rotation_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  qvr_in_if.sink      in_ch,
  qvr_out_if.source   out_ch
);
  import qvr_pkg::*;

  qvr_quat_t            quat_r;
  logic                 adv;
  logic                 n_valid, s_valid, d_valid;
  qvr_side_t            n_side, s_side;
  logic [SumW-1:0]      n_sum;
  logic [LenW-1:0]      s_len;
  qvr_unit_t            d_unit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r.w <= QuatWReset;
      quat_r.x <= '0;
      quat_r.y <= '0;
      quat_r.z <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CfgQuatW: quat_r.w <= $signed(cfg_wdata);
        CfgQuatX: quat_r.x <= $signed(cfg_wdata);
        CfgQuatY: quat_r.y <= $signed(cfg_wdata);
        CfgQuatZ: quat_r.z <= $signed(cfg_wdata);
        default:  quat_r.w <= quat_r.w;
      endcase
    end
  end

  // The whole pipeline advances together, so a transaction is accepted whenever it moves.
  assign in_ch.ready = adv;

  qvr_norm u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (in_ch.valid),
    .vec_x   (in_ch.vec_x),
    .vec_y   (in_ch.vec_y),
    .vec_z   (in_ch.vec_z),
    .vec_w   (in_ch.vec_w),
    .valid_o (n_valid),
    .side_o  (n_side),
    .sum_o   (n_sum)
  );

  qvr_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (n_valid),
    .side_i  (n_side),
    .sum_i   (n_sum),
    .valid_o (s_valid),
    .side_o  (s_side),
    .len_o   (s_len)
  );

  qvr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (s_valid),
    .side_i  (s_side),
    .len_i   (s_len),
    .valid_o (d_valid),
    .unit_o  (d_unit)
  );

  qvr_rot u_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .quat    (quat_r),
    .valid_i (d_valid),
    .unit_i  (d_unit),
    .adv     (adv),
    .out_ch  (out_ch)
  );

  // Backpressure on the input only ever comes from a result waiting at the output.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without a waiting result");

  // A zero-length vector must come out as all zeros.
  a_zero_length_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.zero_length) |->
      (out_ch.out_x == '0 && out_ch.out_y == '0 && out_ch.out_z == '0))
    else $error("zero-length result carries nonzero components");

  // A result that was not taken is still offered with the same flags next cycle.
  a_stall_holds_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.zero_length) && $stable(out_ch.out_w)))
    else $error("stalled result changed");
endmodule

@@ sim/quaternion_vector_rotation_top_test.sv @@
// Self-checking testbench for the quaternion vector rotation top level.
`timescale 1ns / 100ps

module quaternion_vector_rotation_top_test;
  import qvr_pkg::*;

  // One expected result transaction of the block.
  typedef struct {
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] y;
    logic signed [OutW-1:0] z;
    logic                   w;
    logic                   zl;
  } rotated_vec_t;

  localparam int DrainCycles = 90;
  localparam int StallLimit  = 20000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  qvr_in_if  in_ch ();
  qvr_out_if out_ch ();

  quaternion_vector_rotation_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // The testbench keeps its own copy of the rotation quaternion.
  qvr_quat_t    rot_quat;
  rotated_vec_t expected_rotations[$];
  int           mismatch_count;
  int           burst_left;
  int           idle_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Integer square root, bit by bit, of a 64-bit sum of squares.
  function automatic longint unsigned sqrt_floor(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scales a Q.52 product down to Q3.14 with rounding half away from zero and saturation.
  function automatic logic signed [OutW-1:0] to_q3_14(longint signed r);
    longint unsigned mag;
    longint unsigned q;
    mag = (r < 0) ? longint'(-r) : longint'(r);
    q = (mag + (64'd1 << (OutShift - 1))) >> OutShift;
    if (r < 0) begin
      if (q > 131072) return OutMin;
      return OutW'(-q);
    end
    if (q > 131071) return OutMax;
    return OutW'(q);
  endfunction

  // Works out the rotated unit vector for one input vector under the current quaternion.
  function automatic rotated_vec_t rotate_vector(logic [31:0] vx, logic [31:0] vy,
                                                 logic [31:0] vz, logic [31:0] vw);
    rotated_vec_t    res;
    logic [31:0]     comp[3];
    longint unsigned mag[3];
    logic            neg[3];
    longint unsigned top_mag;
    longint unsigned sum;
    longint unsigned len;
    longint unsigned num;
    longint unsigned quo;
    longint signed   u[3];
    longint signed   qw, qx, qy, qz, s, d, cx, cy, cz;
    comp[0] = vx;
    comp[1] = vy;
    comp[2] = vz;
    top_mag = 0;
    sum = 0;
    // A negative weight flips the direction; a zero weight counts as positive.
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i][31] ? (64'h1_0000_0000 - comp[i]) : comp[i];
      neg[i] = comp[i][31] ^ vw[31];
      if (mag[i] > top_mag) top_mag = mag[i];
    end
    res.w = (vw != 0);
    res.zl = 1'b0;
    if (top_mag == 0) begin
      res.x = '0;
      res.y = '0;
      res.z = '0;
      res.zl = 1'b1;
      return res;
    end
    while (top_mag < (64'd1 << PreTarget)) begin
      top_mag <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = sqrt_floor(sum);
    for (int i = 0; i < 3; i++) begin
      num = mag[i] << 24;
      quo = num / len;
      if (2 * (num % len) >= len) quo++;
      u[i] = neg[i] ? -longint'(quo) : longint'(quo);
    end
    qw = rot_quat.w;
    qx = rot_quat.x;
    qy = rot_quat.y;
    qz = rot_quat.z;
    s  = qw * qw - qx * qx - qy * qy - qz * qz;
    d  = qx * u[0] + qy * u[1] + qz * u[2];
    cx = qy * u[2] - qz * u[1];
    cy = qz * u[0] - qx * u[2];
    cz = qx * u[1] - qy * u[0];
    res.x = to_q3_14(s * u[0] + 2 * d * qx + 2 * qw * cx);
    res.y = to_q3_14(s * u[1] + 2 * d * qy + 2 * qw * cy);
    res.z = to_q3_14(s * u[2] + 2 * d * qz + 2 * qw * cz);
    return res;
  endfunction

  // Sends one vector; the sender works in bursts with random gaps between them.
  task automatic send_vector(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                             logic [31:0] vw);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.vec_x <= vx;
    in_ch.vec_y <= vy;
    in_ch.vec_z <= vz;
    in_ch.vec_w <= vw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_rotations.push_back(rotate_vector(vx, vy, vz, vw));
  endtask

  // Drops valid, waits for every result, then lets the pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_rotations.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Writes all four quaternion registers; the block must be idle.
  task automatic load_quaternion(logic signed [15:0] qw, logic signed [15:0] qx,
                                 logic signed [15:0] qy, logic signed [15:0] qz);
    logic [15:0] vals[4];
    logic [1:0]  idx[4];
    vals = '{qw, qx, qy, qz};
    idx  = '{CfgQuatW, CfgQuatX, CfgQuatY, CfgQuatZ};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[i];
      cfg_wdata <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    rot_quat.w = qw;
    rot_quat.x = qx;
    rot_quat.y = qy;
    rot_quat.z = qz;
  endtask

  // Draws a component: full range, a short value that needs prescaling, zero or an extreme.
  function automatic logic [31:0] pick_component();
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3, 4:    return $signed($urandom) >>> $urandom_range(1, 31);
      5:       return '0;
      6:       return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom_range(0, 3) - 2;
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Extremes of the fields, the axes, a reversed weight and the zero-length vector.
  task automatic test_directed_vectors();
    send_vector(32'd1, 32'd0, 32'd0, 32'd1);
    send_vector(32'd0, 32'd1, 32'd0, 32'd0);
    send_vector(32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
    send_vector(32'd0, 32'd0, 32'd0, 32'd0);
    send_vector(32'd0, 32'd0, 32'd0, 32'h8000_0000);
    send_vector(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd5);
    send_vector(32'd3, 32'd4, 32'd0, 32'hFFFF_FFF0);
    send_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F, 32'h1234_5678);
  endtask

  // Repeats the directed vectors under quaternions that rotate, scale down and saturate.
  task automatic test_quaternion_extremes();
    logic signed [15:0] qset[6][4];
    qset = '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0},
             '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585},
             '{16'sd0, 16'sd16384, 16'sd0, 16'sd0},
             '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
             '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
             '{16'sd0, 16'sd0, 16'sd0, 16'sd0}};
    for (int k = 0; k < 6; k++) begin
      wait_idle();
      load_quaternion(qset[k][0], qset[k][1], qset[k][2], qset[k][3]);
      test_directed_vectors();
    end
  endtask

  // Random vectors in phases, each with a fresh random quaternion, in most phases at half range.
  task automatic test_random_vectors();
    logic signed [15:0] q[4];
    for (int phase = 0; phase < 10; phase++) begin
      wait_idle();
      for (int i = 0; i < 4; i++) begin
        if (phase % 3 == 0) begin
          q[i] = 16'($urandom);
        end else begin
          q[i] = $signed(16'($urandom)) >>> 1;
        end
      end
      load_quaternion(q[0], q[1], q[2], q[3]);
      repeat (130) send_vector(pick_component(), pick_component(), pick_component(),
                               pick_weight());
    end
  endtask

  // The receiver alternates between always ready and random stalls, with rare long stalls.
  int stall_left;
  int ready_cycle;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      ready_cycle = 0;
    end else begin
      ready_cycle++;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 2) begin
        stall_left = $urandom_range(5, 40);
        out_ch.ready <= 1'b0;
      end else if ((ready_cycle / 300) % 2 == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Each accepted result is compared with the oldest expected transaction.
  rotated_vec_t exp_vec;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rotations.size() == 0) begin
        $error("result transaction with no expectation waiting");
        mismatch_count++;
      end else begin
        exp_vec = expected_rotations.pop_front();
        if (out_ch.out_x !== exp_vec.x) begin
          $error("out_x expected %0d actual %0d", exp_vec.x, out_ch.out_x);
          mismatch_count++;
        end
        if (out_ch.out_y !== exp_vec.y) begin
          $error("out_y expected %0d actual %0d", exp_vec.y, out_ch.out_y);
          mismatch_count++;
        end
        if (out_ch.out_z !== exp_vec.z) begin
          $error("out_z expected %0d actual %0d", exp_vec.z, out_ch.out_z);
          mismatch_count++;
        end
        if (out_ch.out_w !== exp_vec.w) begin
          $error("out_w expected %0d actual %0d", exp_vec.w, out_ch.out_w);
          mismatch_count++;
        end
        if (out_ch.zero_length !== exp_vec.zl) begin
          $error("zero_length expected %0d actual %0d", exp_vec.zl, out_ch.zero_length);
          mismatch_count++;
        end
      end
    end
  end

  // The watchdog ends a run that stops moving transactions for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("FAIL quaternion_vector_rotation_top");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.vec_x = '0;
    in_ch.vec_y = '0;
    in_ch.vec_z = '0;
    in_ch.vec_w = '0;
    burst_left = 0;
    rot_quat = '{w: QuatWReset, x: '0, y: '0, z: '0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset leaves the identity rotation in place.
    test_directed_vectors();
    test_quaternion_extremes();
    test_random_vectors();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("PASS quaternion_vector_rotation_top");
    end else begin
      $display("FAIL quaternion_vector_rotation_top");
    end
    $finish;
  end

endmodule
